>>> rtl/ttad_pkg.sv
// ----------------------------------------------------------------------------
// ttad_pkg
// Shared types and constants of the two-tap ADPCM frame decoder.
// ----------------------------------------------------------------------------
package ttad_pkg;

	localparam int COEF_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int SCALE_W  = 17;
	localparam int MUL_W    = 17;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int Q_SHIFT  = 12;

	localparam logic signed [COEF_W-1:0] COEF_ONE_RESET = 16'sd7334;
	localparam logic signed [COEF_W-1:0] COEF_TWO_RESET = -16'sd3284;

	typedef logic [0:0] reg_index_t;
	localparam reg_index_t REG_COEF_ONE = 1'b0;
	localparam reg_index_t REG_COEF_TWO = 1'b1;

	typedef struct packed {
		logic [2:0] channel_index;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] pcm_sample;
		logic [2:0]                 sample_channel;
		logic                       last_of_byte;
	} out_item_t;

	// datapath operation issued by the sequencer in one step
	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DISPATCH,
		OP_MUL_ONE,
		OP_MUL_TWO,
		OP_MUL_SCALE,
		OP_EMIT
	} op_t;

	// conditions seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic no_sample;
		logic high_nibble;
	} ttad_status_t;

	// datapath flags toward the sequencer
	typedef struct packed {
		logic no_sample;
		logic high_nibble;
	} ttad_dp_flags_t;

endpackage

>>> rtl/ttad_stream_if.sv
// ----------------------------------------------------------------------------
// ttad_stream_if
// Valid/ready stream channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface ttad_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/ttad_sequencer.sv
// ----------------------------------------------------------------------------
// ttad_sequencer
// Step counter and control store; issues one datapath operation per step.
// ----------------------------------------------------------------------------
module ttad_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttad_pkg::ttad_status_t status,
	output ttad_pkg::op_t         op,
	output logic                  take_input
);
	import ttad_pkg::*;

	localparam int PROG_LEN = 6;
	localparam int STEP_W   = 3;

	typedef enum logic [1:0] {
		WC_NONE,
		WC_INPUT,
		WC_OUTPUT
	} wait_cond_t;

	typedef enum logic [1:0] {
		JC_NEVER,
		JC_NO_SAMPLE,
		JC_HIGH_NIBBLE
	} jump_cond_t;

	typedef struct packed {
		op_t               op;
		wait_cond_t        hold;
		jump_cond_t        jump;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	localparam logic [STEP_W-1:0] STEP_ACCEPT = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MUL    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LAST   = 3'(PROG_LEN - 1);

	localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
		'{OP_ACCEPT,    WC_INPUT,  JC_NEVER,       STEP_ACCEPT},
		'{OP_DISPATCH,  WC_NONE,   JC_NO_SAMPLE,   STEP_ACCEPT},
		'{OP_MUL_ONE,   WC_NONE,   JC_NEVER,       STEP_ACCEPT},
		'{OP_MUL_TWO,   WC_NONE,   JC_NEVER,       STEP_ACCEPT},
		'{OP_MUL_SCALE, WC_NONE,   JC_NEVER,       STEP_ACCEPT},
		'{OP_EMIT,      WC_OUTPUT, JC_HIGH_NIBBLE, STEP_MUL}
	};

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	ctrl_word_t        word;
	logic              waiting;
	logic              jump_taken;

	assign word = PROGRAM[step_q];

	always_comb begin
		unique case (word.hold)
			WC_INPUT:  waiting = !status.in_valid;
			WC_OUTPUT: waiting = status.out_busy;
			default:   waiting = 1'b0;
		endcase
		unique case (word.jump)
			JC_NO_SAMPLE:   jump_taken = status.no_sample;
			JC_HIGH_NIBBLE: jump_taken = status.high_nibble;
			default:        jump_taken = 1'b0;
		endcase
		if (waiting) begin
			step_next = step_q;
		end else if (jump_taken) begin
			step_next = word.target;
		end else if (step_q == STEP_LAST) begin
			step_next = STEP_ACCEPT;
		end else begin
			step_next = step_q + 3'd1;
		end
	end

	// hold the operation back while waiting on a channel
	assign op         = waiting ? OP_NONE : word.op;
	assign take_input = (word.hold == WC_INPUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_ACCEPT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

>>> rtl/ttad_datapath.sv
// ----------------------------------------------------------------------------
// ttad_datapath
// Per-channel frame state, shared multiplier, accumulator and sample clamp.
// ----------------------------------------------------------------------------
module ttad_datapath #(
	parameter int CHANNELS    = 8,
	parameter int FRAME_BYTES = 18
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ttad_pkg::op_t                          op,
	input  ttad_pkg::in_item_t                     in_item,
	input  logic signed [ttad_pkg::COEF_W-1:0]     coef_one,
	input  logic signed [ttad_pkg::COEF_W-1:0]     coef_two,
	output ttad_pkg::ttad_dp_flags_t               flags,
	output logic signed [ttad_pkg::SAMPLE_W-1:0]   sample,
	output logic [2:0]                             sample_channel
);
	import ttad_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int SUM_W = PROD_W + 1;

	localparam logic [POS_W-1:0] POS_SCALE_LO = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);

	logic [POS_W-1:0]                 position_q [CHANNELS];
	logic signed [SCALE_W-1:0]        scale_q    [CHANNELS];
	logic signed [SAMPLE_W-1:0]       prev_q     [CHANNELS];
	logic signed [SAMPLE_W-1:0]       older_q    [CHANNELS];

	logic [2:0]                       ch_q;
	logic [7:0]                       byte_q;
	logic                             hi_q;
	logic signed [PROD_W-1:0]         prod_q;
	logic signed [PROD_W-1:0]         acc_q;

	logic [CH_W+2:0]                  ch_ext;
	logic [CH_W-1:0]                  ch_idx;
	logic                             ch_ok;
	logic [POS_W-1:0]                 pos_rd;
	logic signed [SCALE_W-1:0]        scale_rd;
	logic signed [15:0]               header;
	logic [3:0]                       nibble;
	logic signed [MUL_W-1:0]          mul_a;
	logic signed [MUL_W-1:0]          mul_b;
	logic signed [SUM_W-1:0]          sum;

	assign ch_ext   = (CH_W + 3)'(ch_q);
	assign ch_idx   = ch_ext[CH_W-1:0];
	assign ch_ok    = (32'(ch_q) < CHANNELS);
	assign pos_rd   = position_q[ch_idx];
	assign scale_rd = scale_q[ch_idx];
	assign header   = {scale_rd[15:8], byte_q};
	assign nibble   = hi_q ? byte_q[7:4] : byte_q[3:0];

	assign flags.no_sample   = !ch_ok || (pos_rd == '0) || (pos_rd == POS_SCALE_LO);
	assign flags.high_nibble = hi_q;

	always_comb begin
		case (op)
			OP_MUL_ONE: begin
				mul_a = {coef_one[COEF_W-1], coef_one};
				mul_b = {prev_q[ch_idx][SAMPLE_W-1], prev_q[ch_idx]};
			end
			OP_MUL_TWO: begin
				mul_a = {coef_two[COEF_W-1], coef_two};
				mul_b = {older_q[ch_idx][SAMPLE_W-1], older_q[ch_idx]};
			end
			default: begin
				mul_a = {{(MUL_W-4){nibble[3]}}, nibble};
				mul_b = scale_rd;
			end
		endcase
	end

	// floor division of the prediction is the arithmetic shift
	assign sum = SUM_W'(prod_q) + SUM_W'(acc_q >>> Q_SHIFT);

	always_comb begin
		if (sum > SUM_W'(32767)) begin
			sample = 16'sh7FFF;
		end else if (sum < -SUM_W'(32768)) begin
			sample = -16'sh8000;
		end else begin
			sample = sum[SAMPLE_W-1:0];
		end
	end

	assign sample_channel = ch_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				ch_q   <= in_item.channel_index;
				byte_q <= in_item.data_byte;
			end
			OP_MUL_ONE:   prod_q <= mul_a * mul_b;
			OP_MUL_TWO: begin
				acc_q  <= prod_q;
				prod_q <= mul_a * mul_b;
			end
			OP_MUL_SCALE: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= mul_a * mul_b;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= 1'b1;
			for (int i = 0; i < CHANNELS; i++) begin
				position_q[i] <= '0;
				scale_q[i]    <= '0;
				prev_q[i]     <= '0;
				older_q[i]    <= '0;
			end
		end else begin
			case (op)
				OP_DISPATCH: begin
					hi_q <= 1'b1;
					if (ch_ok) begin
						position_q[ch_idx] <= (pos_rd == POS_LAST) ? '0 : pos_rd + 1'b1;
						if (pos_rd == '0) begin
							scale_q[ch_idx] <= {1'b0, byte_q, 8'h00};
						end else if (pos_rd == POS_SCALE_LO) begin
							scale_q[ch_idx] <= {header[15], header} + 17'sd1;
						end
					end
				end
				OP_EMIT: begin
					hi_q            <= 1'b0;
					older_q[ch_idx] <= prev_q[ch_idx];
					prev_q[ch_idx]  <= sample;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/two_tap_adpcm_frame_decoder.sv
// ----------------------------------------------------------------------------
// two_tap_adpcm_frame_decoder
// Multichannel two-tap ADPCM decoder: one frame byte in, up to two samples out.
// ----------------------------------------------------------------------------
// Header bytes (and bytes of an absent channel) pass the accept and dispatch
// steps only; a data byte adds four steps per nibble (multiply by each
// coefficient, scale, emit) on the shared multiplier and accumulator, plus any
// output stall, before the next byte is taken. Each emit step loads the result.
// Reset clears all channel state at once and loads the default coefficients.
// ----------------------------------------------------------------------------
module two_tap_adpcm_frame_decoder #(
	parameter int CHANNELS    = 8,
	parameter int FRAME_BYTES = 18
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ttad_stream_if.sink                    in_items,
	ttad_stream_if.source                  out_items,
	input  logic                           cfg_wr_en,
	input  ttad_pkg::reg_index_t           cfg_index,
	input  logic [ttad_pkg::COEF_W-1:0]    cfg_data
);
	import ttad_pkg::*;

	logic signed [COEF_W-1:0]   coef_one_q;
	logic signed [COEF_W-1:0]   coef_two_q;
	logic                       out_valid_q;
	out_item_t                  out_item_q;

	op_t                        op;
	logic                       take_input;
	ttad_status_t               status;
	ttad_dp_flags_t             flags;
	logic signed [SAMPLE_W-1:0] sample;
	logic [2:0]                 sample_channel;
	logic                       emit;

	assign status.in_valid    = in_items.valid;
	assign status.out_busy    = out_valid_q && !out_items.ready;
	assign status.no_sample   = flags.no_sample;
	assign status.high_nibble = flags.high_nibble;

	ttad_sequencer u_sequencer (
		.clk        (clk),
		.arst_n     (arst_n),
		.status     (status),
		.op         (op),
		.take_input (take_input)
	);

	ttad_datapath #(
		.CHANNELS    (CHANNELS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.in_item        (in_items.payload),
		.coef_one       (coef_one_q),
		.coef_two       (coef_two_q),
		.flags          (flags),
		.sample         (sample),
		.sample_channel (sample_channel)
	);

	assign in_items.ready    = take_input;
	assign emit              = (op == OP_EMIT);
	assign out_items.valid   = out_valid_q;
	assign out_items.payload = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_one_q  <= COEF_ONE_RESET;
			coef_two_q  <= COEF_TWO_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_COEF_ONE: coef_one_q <= cfg_data;
					REG_COEF_TWO: coef_two_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_items.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.pcm_sample     <= sample;
			out_item_q.sample_channel <= sample_channel;
			out_item_q.last_of_byte   <= !flags.high_nibble;
		end
	end

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(out_valid_q && !out_items.ready))
		else $error("result register overwritten while full");

	// an accepted byte is dispatched in the following step
	a_dispatch_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_items.valid && in_items.ready) |=> (op == OP_DISPATCH))
		else $error("accepted byte not dispatched");

	// the low nibble is still pending after the high-nibble sample
	a_low_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && flags.high_nibble) |=> (!in_items.ready && !flags.high_nibble))
		else $error("byte released before its low nibble");

endmodule

>>> dv/two_tap_adpcm_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// two_tap_adpcm_frame_decoder_tb
// Self-checking bench: streams frame bytes on eight interleaved channels under
// several coefficient settings, predicts every decoded sample in a software
// copy of the channel state and compares each output transaction against it,
// with random idle bursts on both handshakes and one long output back-pressure.
// ----------------------------------------------------------------------------
module two_tap_adpcm_frame_decoder_tb;
	import ttad_pkg::*;

	localparam int CHANNELS    = 8;
	localparam int FRAME_BYTES = 18;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 300;

	// Channel state mirror and the queue of samples still to come out.
	class pcm_predictor;
		int        coef_one;
		int        coef_two;
		int        position [CHANNELS];
		int        scale [CHANNELS];
		int        prev [CHANNELS];
		int        older [CHANNELS];
		out_item_t pending_samples [$];
		int        mismatches;

		function new();
			coef_one   = int'(COEF_ONE_RESET);
			coef_two   = int'(COEF_TWO_RESET);
			mismatches = 0;
			for (int c = 0; c < CHANNELS; c++) begin
				position[c] = 0;
				scale[c]    = 0;
				prev[c]     = 0;
				older[c]    = 0;
			end
		endfunction

		function void set_coef(reg_index_t idx, logic signed [COEF_W-1:0] v);
			if (idx == REG_COEF_ONE) begin
				coef_one = int'(v);
			end else begin
				coef_two = int'(v);
			end
		endfunction

		function int next_sample(int ch, logic [3:0] nib);
			longint acc;
			longint v;
			int     n;
			acc = longint'(coef_one) * prev[ch] + longint'(coef_two) * older[ch];
			n   = nib[3] ? int'(nib) - 16 : int'(nib);
			// arithmetic shift of a signed value floors toward minus infinity
			v   = longint'(n) * scale[ch] + (acc >>> Q_SHIFT);
			if (v > 32767) begin
				v = 32767;
			end
			if (v < -32768) begin
				v = -32768;
			end
			older[ch] = prev[ch];
			prev[ch]  = int'(v);
			return int'(v);
		endfunction

		function void decode_byte(logic [2:0] ch, logic [7:0] b);
			int                  pos;
			logic signed [15:0]  hdr;
			out_item_t           s;
			pos          = position[ch];
			position[ch] = (pos + 1 >= FRAME_BYTES) ? 0 : pos + 1;
			if (pos == 0) begin
				scale[ch] = int'(b) << 8;
				return;
			end
			if (pos == 1) begin
				hdr       = {8'(scale[ch] >> 8), b};
				scale[ch] = int'(hdr) + 1;
				return;
			end
			s.pcm_sample     = 16'(next_sample(ch, b[7:4]));
			s.sample_channel = ch;
			s.last_of_byte   = 1'b0;
			pending_samples.push_back(s);
			s.pcm_sample     = 16'(next_sample(ch, b[3:0]));
			s.last_of_byte   = 1'b1;
			pending_samples.push_back(s);
		endfunction

		function void check_sample(out_item_t got);
			out_item_t want;
			if (pending_samples.size() == 0) begin
				$error("unexpected sample: pcm_sample %0d sample_channel %0d last_of_byte %0d",
					got.pcm_sample, got.sample_channel, got.last_of_byte);
				mismatches++;
				return;
			end
			want = pending_samples.pop_front();
			if (got.pcm_sample !== want.pcm_sample) begin
				$error("pcm_sample: expected %0d, actual %0d", want.pcm_sample, got.pcm_sample);
				mismatches++;
			end
			if (got.sample_channel !== want.sample_channel) begin
				$error("sample_channel: expected %0d, actual %0d",
					want.sample_channel, got.sample_channel);
				mismatches++;
			end
			if (got.last_of_byte !== want.last_of_byte) begin
				$error("last_of_byte: expected %0d, actual %0d",
					want.last_of_byte, got.last_of_byte);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	reg_index_t        cfg_index;
	logic [COEF_W-1:0] cfg_data;

	bit src_idling   = 1'b1;
	bit sink_idling  = 1'b1;
	bit press_start  = 1'b0;
	bit sink_blocked = 1'b0;

	pcm_predictor decoder = new();

	ttad_stream_if #(.payload_t(in_item_t))  in_ch ();
	ttad_stream_if #(.payload_t(out_item_t)) out_ch ();

	two_tap_adpcm_frame_decoder #(
		.CHANNELS    (CHANNELS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_items  (in_ch.sink),
		.out_items (out_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Offer one byte, optionally after an idle burst, and hold until accepted.
	task automatic send_byte(input logic [2:0] ch, input logic [7:0] b);
		int gap;
		if (src_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= '{channel_index: ch, data_byte: b};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		decoder.decode_byte(ch, b);
	endtask

	task automatic write_coef(input reg_index_t idx, input logic [COEF_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		decoder.set_coef(idx, v);
		@(posedge clk);
	endtask

	// Drop valid, wait for every sample, then let a trailing header byte finish.
	task automatic drain_decoder();
		in_ch.valid <= 1'b0;
		while (decoder.pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Interleaved random frames; headers lean toward small scales.
	task automatic stream_frames(input int count);
		logic [2:0] ch;
		logic [7:0] b;
		repeat (count) begin
			ch = 3'($urandom_range(0, CHANNELS - 1));
			b  = 8'($urandom_range(0, 255));
			if (decoder.position[ch] == 0) begin
				case ($urandom_range(0, 3))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: ;
				endcase
			end
			send_byte(ch, b);
		end
	endtask

	task automatic directed_frames();
		logic [7:0] frame_bytes [21] = '{
			8'h80, 8'h00, 8'h7F, 8'h80, 8'h08, 8'hF7, 8'h00, 8'hFF, 8'h11, 8'hEE, 8'h70,
			8'h07, 8'h8F, 8'hF8, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h7F, 8'hFF, 8'h9C
		};
		// full frame on channel 3 with the most negative scale, then wrap to a new header
		foreach (frame_bytes[i]) begin
			send_byte(3'd3, frame_bytes[i]);
		end
		// zero scale: prediction only
		send_byte(3'd7, 8'hFF);
		send_byte(3'd7, 8'hFF);
		send_byte(3'd7, 8'h7F);
	endtask

	initial begin
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= REG_COEF_ONE;
		cfg_data      <= '0;
		arst_n        <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_frames();
		stream_frames(130);
		drain_decoder();

		write_coef(REG_COEF_ONE, 16'h7FFF);
		write_coef(REG_COEF_TWO, 16'h8000);
		press_start = 1'b1;
		stream_frames(130);
		drain_decoder();

		write_coef(REG_COEF_ONE, 16'h8000);
		write_coef(REG_COEF_TWO, 16'h7FFF);
		stream_frames(130);
		drain_decoder();

		write_coef(REG_COEF_ONE, 16'h0000);
		write_coef(REG_COEF_TWO, 16'h0000);
		stream_frames(130);
		drain_decoder();

		write_coef(REG_COEF_ONE, 16'($urandom));
		write_coef(REG_COEF_TWO, 16'($urandom));
		stream_frames(130);
		drain_decoder();

		// stable predictor, full rate on both sides
		src_idling  = 1'b0;
		sink_idling = 1'b0;
		write_coef(REG_COEF_ONE, 16'($urandom_range(0, 8191)));
		write_coef(REG_COEF_TWO, 16'(-$urandom_range(0, 4096)));
		stream_frames(130);
		drain_decoder();

		if (decoder.mismatches == 0) begin
			$display("** two_tap_adpcm_frame_decoder: PASSED **");
		end else begin
			$display("** two_tap_adpcm_frame_decoder: FAILED **");
		end
		$finish;
	end

	// Output ready with random stall bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_blocked) begin
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (sink_idling && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Long back-pressure so the decoder fills up and stalls its input.
	initial begin
		wait (press_start);
		sink_blocked = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_blocked = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			decoder.check_sample(out_ch.payload);
		end
	end

	initial begin
		#3_000_000;
		$display("** two_tap_adpcm_frame_decoder: FAILED **");
		$finish;
	end

endmodule
